[rtl/core/scrolling_text_column_generator_macros.svh]
// Assertion macros for the scrolling text column generator
`ifndef SCROLLING_TEXT_COLUMN_GENERATOR_MACROS_SVH
`define SCROLLING_TEXT_COLUMN_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define SCG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCG_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/stcg_pkg.sv]
// Package: widths, register map, font ROM and helper functions
package stcg_pkg;

  localparam int unsigned PANEL_COLUMNS_DEF = 64;
  localparam int unsigned MAX_CHARS_DEF     = 8;

  localparam int unsigned COL_W    = 6;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned BASE_W   = 9;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned TEXT_W   = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned GAP_W    = 3;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 64;

  localparam int unsigned GLYPH_W   = 7;
  localparam int unsigned SLOT_W    = 4;   // 7 + gap, at most 14
  localparam int unsigned TOT_W     = 7;   // 8 slots of 14, at most 112
  localparam int unsigned REM_W     = 17;  // column + offset
  localparam int unsigned GIDX_W    = 6;   // glyph number, 0..38
  localparam int unsigned GCOL_W    = 3;
  localparam int unsigned CIDX_W    = 3;

  // restoring modulo: 7 << 15 exceeds any column + offset sum
  localparam int unsigned MOD_TOP   = 14;
  localparam int unsigned MOD_STEPS = 4;   // steps per stage

  localparam logic [1:0] REG_TEXT_CHARS  = 2'd0;
  localparam logic [1:0] REG_TEXT_LENGTH = 2'd1;
  localparam logic [1:0] REG_CHAR_GAP    = 2'd2;

  localparam logic [LEN_W-1:0] TEXT_LENGTH_RST = 4'd8;
  localparam logic [GAP_W-1:0] CHAR_GAP_RST    = 3'd1;

  localparam logic [GIDX_W-1:0] GLYPH_BLANK = 6'd0;
  localparam logic [GIDX_W-1:0] GLYPH_A     = 6'd1;
  localparam logic [GIDX_W-1:0] GLYPH_EXCL  = 6'd27;
  localparam logic [GIDX_W-1:0] GLYPH_ZERO  = 6'd28;
  localparam logic [GIDX_W-1:0] GLYPH_COMMA = 6'd38;

  // Up to MOD_STEPS restoring steps, shifts k_hi down to k_hi - n + 1
  function automatic logic [REM_W-1:0] mod_steps(input logic [REM_W-1:0] r,
                                                 input logic [TOT_W-1:0] total,
                                                 input int unsigned k_hi,
                                                 input int unsigned n);
    logic [31:0] acc;
    logic [31:0] d;
    acc = 32'(r);
    for (int unsigned j = 0; j < MOD_STEPS; j++) begin
      if (j < n) begin
        d = 32'(total) << (k_hi - j);
        if (acc >= d) acc = acc - d;
      end
    end
    return REM_W'(acc);
  endfunction

  function automatic logic [GIDX_W-1:0] glyph_of(input logic [7:0] ch);
    logic [GIDX_W-1:0] g;
    g = GLYPH_BLANK;
    if (ch >= 8'h41 && ch <= 8'h5A)      g = GLYPH_A + GIDX_W'(ch - 8'h41);
    else if (ch >= 8'h61 && ch <= 8'h7A) g = GLYPH_A + GIDX_W'(ch - 8'h61);
    else if (ch == 8'h21)                g = GLYPH_EXCL;
    else if (ch >= 8'h30 && ch <= 8'h39) g = GLYPH_ZERO + GIDX_W'(ch - 8'h30);
    else if (ch == 8'h2C)                g = GLYPH_COMMA;
    return g;
  endfunction

  // Glyph rows, row y in bits [8y+7:8y]; bit c of a row is glyph column c
  function automatic logic [63:0] glyph_rows(input logic [GIDX_W-1:0] g);
    logic [63:0] r;
    case (g)
      6'd1:  r = 64'h3333_333F_3333_1E0C;
      6'd2:  r = 64'h3F66_6666_3E66_663F;
      6'd3:  r = 64'h3C66_0303_0303_663C;
      6'd4:  r = 64'h1F36_6666_6666_361F;
      6'd5:  r = 64'h7F46_0616_1E16_467F;
      6'd6:  r = 64'h0F06_0616_1E16_467F;
      6'd7:  r = 64'h7C66_7303_0303_663C;
      6'd8:  r = 64'h3333_3333_3F33_3333;
      6'd9:  r = 64'h1E0C_0C0C_0C0C_0C1E;
      6'd10: r = 64'h1E33_3330_3030_3078;
      6'd11: r = 64'h6766_6636_1E36_6667;
      6'd12: r = 64'h7F66_4606_0606_060F;
      6'd13: r = 64'h6363_636B_7F7F_7763;
      6'd14: r = 64'h6363_6373_7B6F_6763;
      6'd15: r = 64'h1C36_6363_6363_361C;
      6'd16: r = 64'h0F06_0606_3E66_663F;
      6'd17: r = 64'h381E_3B33_3333_331E;
      6'd18: r = 64'h6766_6636_3E66_663F;
      6'd19: r = 64'h1E33_7038_0E07_331E;
      6'd20: r = 64'h1E0C_0C0C_0C0C_2D3F;
      6'd21: r = 64'h1C36_3333_3333_3333;
      6'd22: r = 64'h0C1E_3633_3333_3333;
      6'd23: r = 64'h6377_7F6B_6363_6363;
      6'd24: r = 64'h6363_361C_1C36_6363;
      6'd25: r = 64'h1E0C_0C0C_1E33_3333;
      6'd26: r = 64'h7F63_060C_1830_637F;
      6'd27: r = 64'h1800_1818_183C_3C18;
      6'd28: r = 64'h3E63_676F_7B73_633E;
      6'd29: r = 64'h3F0C_0C0C_0C0C_0E0C;
      6'd30: r = 64'h3F33_0306_1C30_331E;
      6'd31: r = 64'h1E33_3030_1C30_331E;
      6'd32: r = 64'h7830_307F_3336_3C38;
      6'd33: r = 64'h1E33_3030_301F_033F;
      6'd34: r = 64'h1E33_3333_1F03_061C;
      6'd35: r = 64'h0C0C_0C0C_1830_333F;
      6'd36: r = 64'h1E33_3333_1E33_331E;
      6'd37: r = 64'h0E18_3030_3E33_331E;
      6'd38: r = 64'h060C_0C00_0000_0000;
      default: r = 64'h0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/scrolling_text_column_generator.sv]
// Top level: pipelined scrolling text column generator with APB register port
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_ready_o   column_i, scroll_offset_i
//   out       source     out_valid_o/out_ready_i led_base_o, column_bits_o
//   apb cfg   slave      psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// One transaction per cycle sustained while out_ready_i holds; each result
// passes through 7 register stages. The depth is set by the capture stage,
// the 15-step restoring modulo over four stages, then a slot divide/glyph stage
// and the font ROM output stage.
// rst_ni clears all valid bits and loads register reset values; no clearing pass.
// A stall on out holds occupied stages with no empty stage downstream; empty stages still fill.
`include "scrolling_text_column_generator_macros.svh"
module scrolling_text_column_generator #(
  parameter int unsigned PANEL_COLUMNS = stcg_pkg::PANEL_COLUMNS_DEF,
  parameter int unsigned MAX_CHARS     = stcg_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [stcg_pkg::COL_W-1:0]    column_i,
  input  logic [stcg_pkg::OFFS_W-1:0]   scroll_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [stcg_pkg::BASE_W-1:0]   led_base_o,
  output logic [stcg_pkg::PIX_W-1:0]    column_bits_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stcg_pkg::PADDR_W-1:0]  paddr,
  input  logic [stcg_pkg::PDATA_W-1:0]  pwdata,
  output logic [stcg_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import stcg_pkg::*;

  // Stage map:
  //   0 capture column + offset
  //   1..3 modulo steps (4 shifts each), 4 last 3 shifts -> banner column
  //   5 slot divide, character pick, ASCII to glyph
  //   6 ROM column extract, serpentine flip (output register)
  localparam int unsigned NST        = 7;
  localparam int unsigned MOD_STAGES = 4;   // stages holding a partial remainder
  localparam int unsigned ST_SRC     = 4;
  localparam int unsigned ST_GLYPH   = 5;
  localparam int unsigned ST_OUT     = 6;

  typedef struct packed {
    logic [GIDX_W-1:0] glyph;
    logic [GCOL_W-1:0] gcol;
    logic              dark;
  } glyph_stage_t;

  // ---------------- configuration registers ----------------
  logic [TEXT_W-1:0] text_q;
  logic [LEN_W-1:0]  text_len_q;
  logic [GAP_W-1:0]  gap_q;
  logic [LEN_W-1:0]  len_eff;
  logic [SLOT_W-1:0] slot_d, slot_q;
  logic [TOT_W-1:0]  total_d, total_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q     <= '0;
      text_len_q <= TEXT_LENGTH_RST;
      gap_q      <= CHAR_GAP_RST;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:3])
        REG_TEXT_CHARS:  text_q     <= pwdata[TEXT_W-1:0];
        REG_TEXT_LENGTH: text_len_q <= pwdata[LEN_W-1:0];
        REG_CHAR_GAP:    gap_q      <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:3])
      REG_TEXT_CHARS:  prdata = PDATA_W'(text_q);
      REG_TEXT_LENGTH: prdata = PDATA_W'(text_len_q);
      REG_CHAR_GAP:    prdata = PDATA_W'(gap_q);
      default:         prdata = '0;
    endcase
  end

  // Banner geometry, re-registered every cycle. The user must move config only while
  // idle (the block does not enforce this), so this is settled before any transaction reaches stage 1.
  always_comb begin
    if (text_len_q == '0)                      len_eff = LEN_W'(1);
    else if (text_len_q > LEN_W'(MAX_CHARS))   len_eff = LEN_W'(MAX_CHARS);
    else                                       len_eff = text_len_q;
    slot_d  = SLOT_W'(GLYPH_W) + SLOT_W'(gap_q);
    total_d = TOT_W'(len_eff) * TOT_W'(slot_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SLOT_W'(GLYPH_W) + SLOT_W'(CHAR_GAP_RST);
      total_q <= TOT_W'(TEXT_LENGTH_RST) * (TOT_W'(GLYPH_W) + TOT_W'(CHAR_GAP_RST));
    end else begin
      slot_q  <= slot_d;
      total_q <= total_d;
    end
  end

  // ---------------- pipeline flow control ----------------
  logic [NST-1:0] v_q;
  logic [NST-1:0] free;   // stage may load this cycle

  always_comb begin
    free[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int i = NST - 2; i >= 0; i--) begin
      free[i] = !v_q[i] || free[i+1];
    end
  end

  assign in_ready_o  = free[0];
  assign out_valid_o = v_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (free[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (free[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ---------------- datapath ----------------
  logic [COL_W-1:0]  col_q [ST_OUT];
  logic [REM_W-1:0]  rem_q [MOD_STAGES];
  logic [TOT_W-1:0]  src_q;
  glyph_stage_t      gs_d, gs_q;
  logic [REM_W-1:0]  src_full;

  assign src_full = mod_steps(rem_q[MOD_STAGES-1], total_q,
                              MOD_TOP - (MOD_STAGES - 1) * MOD_STEPS,
                              MOD_TOP + 1 - (MOD_STAGES - 1) * MOD_STEPS);

  // stage 5: split banner column into character index and glyph column
  always_comb begin
    logic [TOT_W:0]    r;
    logic [TOT_W:0]    d;
    logic [CIDX_W-1:0] idx;
    logic [7:0]        ch;
    r   = {1'b0, src_q};
    idx = '0;
    for (int k = CIDX_W - 1; k >= 0; k--) begin
      d = (TOT_W + 1)'(slot_q) << k;
      if (r >= d) begin
        r      = r - d;
        idx[k] = 1'b1;
      end
    end
    ch       = text_q[{idx, 3'b000} +: 8];
    gs_d.glyph = glyph_of(ch);
    gs_d.gcol  = r[GCOL_W-1:0];
    // gap columns and columns off the panel are dark
    gs_d.dark  = (r >= (TOT_W + 1)'(GLYPH_W)) ||
                 ((BASE_W)'(col_q[ST_GLYPH-1]) >= BASE_W'(PANEL_COLUMNS));
  end

  // stage 6: one glyph column, flipped on odd (upward wired) columns
  logic [PIX_W-1:0]  bits_d;
  logic [63:0]       rows;

  always_comb begin
    rows   = glyph_rows(gs_q.glyph);
    bits_d = '0;
    for (int y = 0; y < PIX_W; y++) begin
      if (col_q[ST_OUT-1][0]) bits_d[3'(PIX_W - 1 - y)] = rows[{3'(y), gs_q.gcol}];
      else                    bits_d[3'(y)]             = rows[{3'(y), gs_q.gcol}];
    end
    if (gs_q.dark) bits_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      col_q[0] <= column_i;
      rem_q[0] <= REM_W'(column_i) + REM_W'(scroll_offset_i);
    end
    for (int i = 1; i < MOD_STAGES; i++) begin
      if (free[i]) begin
        col_q[i] <= col_q[i-1];
        rem_q[i] <= mod_steps(rem_q[i-1], total_q, MOD_TOP - (i - 1) * MOD_STEPS, MOD_STEPS);
      end
    end
    if (free[ST_SRC]) begin
      col_q[ST_SRC] <= col_q[ST_SRC-1];
      src_q         <= src_full[TOT_W-1:0];
    end
    if (free[ST_GLYPH]) begin
      col_q[ST_GLYPH] <= col_q[ST_GLYPH-1];
      gs_q            <= gs_d;
    end
    if (free[ST_OUT]) begin
      led_base_o    <= {col_q[ST_OUT-1], 3'b000};
      column_bits_o <= bits_d;
    end
  end

  // ---------------- assertions ----------------
  // last partial remainder is already below total << 3
  `SCG_ASSERT(a_rem_bound, clk_i, rst_ni, v_q[MOD_STAGES-1] |-> (32'(rem_q[MOD_STAGES-1]) < (32'(total_q) << 3)), "partial remainder out of range")
  // banner column lies inside the banner
  `SCG_ASSERT(a_src_bound, clk_i, rst_ni, v_q[ST_SRC] |-> (src_q < total_q), "banner column beyond banner length")
  // a column off the panel never lights
  `SCG_ASSERT(a_off_panel_dark, clk_i, rst_ni, (out_valid_o && (BASE_W'(led_base_o[BASE_W-1:3]) >= BASE_W'(PANEL_COLUMNS))) |-> (column_bits_o == '0), "off-panel column lit")
  // input backpressure only with every stage full
  `SCG_ASSERT_ALWAYS(a_ready_full, clk_i, !in_ready_o |-> (&v_q), "stall with an empty stage")

endmodule
